// ===== hdl/tsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsl_pkg
// Character codes and command codes for the text scrollback line ring.
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

endpackage

// ===== hdl/text_scrollback_line_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_scrollback_line_ring
// Scrollback store of NUM_LINES text lines of LINE_BYTES bytes, held in one
// synchronous byte memory, with put and read commands.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole memory to zero, one byte a cycle,
// with busy high until the sweep is done. Then one command is taken at a time:
// NUL, carriage return and newline are handled without leaving idle, a printable
// put writes the byte, then the terminator, through the single memory write
// port, and a read steps through capture, address multiply, memory read and
// result. A read result shows on out_char_out for one
// cycle with out_valid high; there is no back-pressure on the result side, so
// the receiver must take it in that cycle.
module text_scrollback_line_ring
  import tsl_pkg::*;
#(
  parameter int NUM_LINES  = 256,
  parameter int LINE_BYTES = 81
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_action,
  input  logic [7:0] in_char_in,
  input  logic [7:0] in_lines_back,
  input  logic [6:0] in_column,
  output logic       out_valid,
  output logic [7:0] out_char_out
);

  localparam int DEPTH = NUM_LINES * LINE_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(NUM_LINES);
  localparam int SW    = $clog2(NUM_LINES + 1);
  localparam int CW    = $clog2(LINE_BYTES);
  localparam int LAST  = LINE_BYTES - 2;
  localparam int EW    = ((LW > 8) ? LW : 8) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT_TERM,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

  state_t        state_r;
  logic [AW-1:0] clr_addr_r;
  logic [LW-1:0] write_line_r;
  logic [AW-1:0] line_base_r;
  logic [CW-1:0] wcol_r;
  logic [SW-1:0] stored_lines_r;
  logic [AW-1:0] term_addr_r;
  logic [LW-1:0] rd_line_r;
  logic [6:0]    rd_col_r;
  logic          rd_zero_r;
  logic [AW-1:0] rd_addr_r;

  logic          accept;
  logic          is_put;
  logic          is_skip;
  logic          is_lf;
  logic          at_last;
  logic          line_wrap;
  logic [LW-1:0] write_line_nxt;
  logic [AW-1:0] line_base_nxt;
  logic [AW-1:0] put_addr;
  logic [EW-1:0] wl_e;
  logic [EW-1:0] bk_e;
  logic [EW-1:0] sel_e;
  logic          rd_zero_nxt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign is_put  = (in_action == ACT_PUT);
  assign is_skip = (in_char_in == CH_NUL) || (in_char_in == CH_CR);
  assign is_lf   = (in_char_in == CH_LF);
  assign at_last = (wcol_r == CW'(LAST));

  assign line_wrap      = (write_line_r == LW'(NUM_LINES - 1));
  assign write_line_nxt = line_wrap ? '0 : write_line_r + 1'b1;
  assign line_base_nxt  = line_wrap ? '0 : line_base_r + AW'(LINE_BYTES);
  assign put_addr       = line_base_r + AW'(wcol_r);

  // line lookup, wrapped without going below zero
  assign wl_e  = EW'(write_line_r);
  assign bk_e  = EW'(in_lines_back);
  assign sel_e = (wl_e >= bk_e) ? (wl_e - bk_e) : (wl_e + EW'(NUM_LINES) - bk_e);
  assign rd_zero_nxt = (bk_e >= EW'(stored_lines_r)) ||
                       ({2'b00, in_column} >= 9'(LINE_BYTES));

  // memory write port; reads are only issued in states with no write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = put_addr;
    ram_wdata = CH_NUL;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      ST_IDLE: begin
        if (accept && is_put) begin
          if (is_lf) begin
            ram_we    = 1'b1;
            ram_waddr = line_base_nxt;
          end else if (!is_skip) begin
            ram_we    = 1'b1;
            ram_wdata = at_last ? CH_PLUS : in_char_in;
          end
        end
      end
      ST_PUT_TERM: begin
        ram_we    = 1'b1;
        ram_waddr = term_addr_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      write_line_r   <= '0;
      line_base_r    <= '0;
      wcol_r         <= '0;
      stored_lines_r <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (is_put) begin
              if (is_lf) begin
                write_line_r <= write_line_nxt;
                line_base_r  <= line_base_nxt;
                wcol_r       <= '0;
                if (stored_lines_r != SW'(NUM_LINES)) begin
                  stored_lines_r <= stored_lines_r + 1'b1;
                end
              end else if (!is_skip) begin
                term_addr_r <= put_addr + 1'b1;
                if (!at_last) begin
                  wcol_r <= wcol_r + 1'b1;
                end
                state_r <= ST_PUT_TERM;
              end
            end else begin
              rd_line_r <= sel_e[LW-1:0];
              rd_col_r  <= in_column;
              rd_zero_r <= rd_zero_nxt;
              state_r   <= ST_RD_ADDR;
            end
          end
        end
        ST_PUT_TERM: begin
          state_r <= ST_IDLE;
        end
        ST_RD_ADDR: begin
          // out-of-range reads are masked, so keep the address inside the memory
          rd_addr_r <= rd_zero_r ? '0 :
                       (AW'(rd_line_r) * AW'(LINE_BYTES) + AW'(rd_col_r));
          state_r   <= ST_RD_MEM;
        end
        ST_RD_MEM: begin
          state_r <= ST_RD_OUT;
        end
        ST_RD_OUT: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  tsl_line_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign out_valid    = (state_r == ST_RD_OUT);
  assign out_char_out = rd_zero_r ? CH_NUL : ram_rdata;

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_READ) |-> ##3 out_valid)
    else $error("read transaction did not give a result three cycles later");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcol_r <= CW'(LAST))
    else $error("write column past last visible position");

  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_lines_r <= SW'(NUM_LINES))
    else $error("stored line count above line count");

  a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
    line_base_r == AW'(AW'(write_line_r) * AW'(LINE_BYTES)))
    else $error("line base out of step with write line");

endmodule

// ===== hdl/tsl_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsl_line_ram
// Single-port-write, single-port-read synchronous byte memory with a
// registered read port.
// ----------------------------------------------------------------------------
module tsl_line_ram #(
  parameter int DEPTH = 20736,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
